FILE: rtl/lip_pkg.sv
`default_nettype none

package lip_pkg;

  typedef enum logic [2:0] {
    ST_START,
    ST_ZERO,
    ST_DEC,
    ST_MINUS,
    ST_HEX0,
    ST_HEX,
    ST_TRAIL
  } state_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_BADCHAR,
    ERR_UOVF,
    ERR_SOVF
  } error_e;

  localparam int unsigned ValueWidth = 64;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0] HexLetterOffset = 4'd9;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_nonzero_dec(input logic [7:0] c);
    return (c >= CH_1) && (c <= CH_9);
  endfunction

  function automatic logic is_hexl(input logic [7:0] c);
    return (c >= CH_A) && (c <= CH_F);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lip_in_if.sv
`default_nettype none

interface lip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last;

  modport source (output valid, output char_byte, output last, input ready);
  modport sink (input valid, input char_byte, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/lip_out_if.sv
`default_nettype none

interface lip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  error_code;

  modport source (output valid, output value, output error_code, input ready);
  modport sink (input valid, input value, input error_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/integer_literal_parser.sv
// A character request is registered at the input, then taken into the
// recognizer, which registers the result of a last character as it takes it.
// Throughput: one character per cycle, set by the combinational multiply-add and
// overflow check in the recognizer update; stalls only while a result waits.
// Reset: asynchronous, active low; clears recognizer state, input and result valid.
`default_nettype none

module integer_literal_parser import lip_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lip_in_if.sink    in_i,
  lip_out_if.source out_o
);

  logic                  s1_valid_q;
  logic [7:0]            s1_char_q;
  logic                  s1_last_q;
  logic                  s1_adv;

  state_e                state_q, state_d;
  logic [ValueWidth-1:0] acc_q, acc_d;
  logic                  minus_q, minus_d;
  error_e                err_q, err_d;

  logic                  out_valid_q;
  logic [ValueWidth-1:0] out_value_q, out_value_d;
  error_e                out_err_q, out_err_d;

  logic [ValueWidth+3:0] dec_sum;
  logic                  dec_ovf;
  logic                  hex_ovf;
  logic [3:0]            hex_digit;

  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  assign dec_sum = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                 + {{(ValueWidth){1'b0}}, s1_char_q[3:0]};
  assign dec_ovf = |dec_sum[ValueWidth+3:ValueWidth];
  assign hex_ovf = |acc_q[ValueWidth-1:ValueWidth-4];
  assign hex_digit = is_hexl(s1_char_q) ? (s1_char_q[3:0] + HexLetterOffset)
                                        : s1_char_q[3:0];

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    minus_d = minus_q;
    err_d   = err_q;
    if (err_q == ERR_NONE) begin
      unique case (state_q)
        ST_START: begin
          priority if (s1_char_q == CH_0) begin
            state_d = ST_ZERO;
            acc_d   = '0;
          end else if (is_nonzero_dec(s1_char_q)) begin
            state_d = ST_DEC;
            acc_d   = {{(ValueWidth-4){1'b0}}, s1_char_q[3:0]};
          end else if (s1_char_q == CH_MINUS) begin
            state_d = ST_MINUS;
            minus_d = 1'b1;
          end else begin
            if (s1_char_q != CH_SPACE) err_d = ERR_BADCHAR;
          end
        end
        ST_ZERO, ST_DEC: begin
          priority if (is_dec(s1_char_q)) begin
            state_d = ST_DEC;
            if (dec_ovf) err_d = ERR_UOVF;
            else acc_d = dec_sum[ValueWidth-1:0];
          end else if (s1_char_q == CH_X && state_q == ST_ZERO) begin
            state_d = ST_HEX0;
          end else if (s1_char_q == CH_SPACE) begin
            state_d = ST_TRAIL;
          end else begin
            err_d = ERR_BADCHAR;
          end
        end
        ST_MINUS: begin
          priority if (s1_char_q == CH_0) begin
            state_d = ST_ZERO;
          end else if (is_nonzero_dec(s1_char_q)) begin
            state_d = ST_DEC;
            acc_d   = {{(ValueWidth-4){1'b0}}, s1_char_q[3:0]};
          end else begin
            err_d = ERR_BADCHAR;
          end
        end
        ST_HEX0, ST_HEX: begin
          priority if (is_dec(s1_char_q) || is_hexl(s1_char_q)) begin
            state_d = ST_HEX;
            if (hex_ovf) err_d = ERR_UOVF;
            else acc_d = {acc_q[ValueWidth-5:0], hex_digit};
          end else if (s1_char_q == CH_SPACE && state_q == ST_HEX) begin
            state_d = ST_TRAIL;
          end else begin
            err_d = ERR_BADCHAR;
          end
        end
        ST_TRAIL: begin
          if (s1_char_q != CH_SPACE) err_d = ERR_BADCHAR;
        end
        default: begin
          err_d = ERR_BADCHAR;
        end
      endcase
    end

    out_err_d = err_d;
    if (out_err_d == ERR_NONE &&
        (state_d == ST_START || state_d == ST_MINUS || state_d == ST_HEX0)) begin
      out_err_d = ERR_BADCHAR;
    end
    if (out_err_d == ERR_NONE && minus_d && acc_d[ValueWidth-1]) begin
      out_err_d = ERR_SOVF;
    end
    if (out_err_d != ERR_NONE) out_value_d = '0;
    else if (minus_d) out_value_d = ~acc_d + {{(ValueWidth-1){1'b0}}, 1'b1};
    else out_value_d = acc_d;
  end

  // hold the input request until the recognizer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_char_q <= in_i.char_byte;
      s1_last_q <= in_i.last;
    end
  end

  // advance the recognizer; a last character returns it to start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      acc_q   <= '0;
      minus_q <= 1'b0;
      err_q   <= ERR_NONE;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        state_q <= ST_START;
        acc_q   <= '0;
        minus_q <= 1'b0;
        err_q   <= ERR_NONE;
      end else begin
        state_q <= state_d;
        acc_q   <= acc_d;
        minus_q <= minus_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_value_q <= out_value_d;
      out_err_q   <= out_err_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.value      = out_value_q;
  assign out_o.error_code = out_err_q;

`ifndef SYNTHESIS
  a_err_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q != ERR_NONE) |-> (out_value_q == '0))
    else $error("error result carries a nonzero value");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (state_q == ST_START && acc_q == '0 && !minus_q
                               && err_q == ERR_NONE && out_valid_q))
    else $error("recognizer not restarted after last character");

  a_err_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_last_q && err_q != ERR_NONE) |=>
      ($stable(acc_q) && $stable(state_q) && $stable(err_q)))
    else $error("recognizer changed after an error");

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !(s1_adv && s1_last_q))
    else $error("result overwritten while pending");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_integer_literal_parser.sv
`timescale 1ns / 1ps

module tb_integer_literal_parser import lip_pkg::*; ();

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned CharsPerPhase = 437;

  class literal_scoreboard;
    typedef struct packed {
      logic [63:0] value;
      error_e      code;
    } literal_result_t;

    state_e          st;
    logic [63:0]     magnitude;
    logic            negative;
    error_e          first_error;
    literal_result_t expected_results[$];
    int unsigned     mismatches;
    int unsigned     code_count[4];

    function new();
      mismatches = 0;
      foreach (code_count[i]) code_count[i] = 0;
      clear_literal();
    endfunction

    function void clear_literal();
      st          = ST_START;
      magnitude   = '0;
      negative    = 1'b0;
      first_error = ERR_NONE;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void add_decimal(logic [3:0] d);
      if (magnitude > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10) first_error = ERR_UOVF;
      else magnitude = magnitude * 64'd10 + 64'(d);
    endfunction

    function void add_hex(logic [3:0] d);
      if (magnitude[63:60] != 4'd0) first_error = ERR_UOVF;
      else magnitude = {magnitude[59:0], d};
    endfunction

    function void step_recognizer(logic [7:0] c);
      logic       dec;
      logic       hexl;
      logic [3:0] dv;
      dec  = (c >= CH_0) && (c <= CH_9);
      hexl = (c >= CH_A) && (c <= CH_F);
      dv   = 4'(c - CH_0);
      case (st)
        ST_START: begin
          if (c == CH_0) begin
            st = ST_ZERO;
            magnitude = '0;
          end else if (dec) begin
            st = ST_DEC;
            magnitude = 64'(dv);
          end else if (c == CH_MINUS) begin
            st = ST_MINUS;
            negative = 1'b1;
          end else if (c != CH_SPACE) begin
            first_error = ERR_BADCHAR;
          end
        end
        ST_ZERO: begin
          if (dec) begin
            st = ST_DEC;
            add_decimal(dv);
          end else if (c == CH_X) begin
            st = ST_HEX0;
          end else if (c == CH_SPACE) begin
            st = ST_TRAIL;
          end else begin
            first_error = ERR_BADCHAR;
          end
        end
        ST_DEC: begin
          if (dec) add_decimal(dv);
          else if (c == CH_SPACE) st = ST_TRAIL;
          else first_error = ERR_BADCHAR;
        end
        ST_MINUS: begin
          if (c == CH_0) begin
            st = ST_ZERO;
          end else if (dec) begin
            st = ST_DEC;
            magnitude = 64'(dv);
          end else begin
            first_error = ERR_BADCHAR;
          end
        end
        ST_HEX0, ST_HEX: begin
          if (dec) begin
            st = ST_HEX;
            add_hex(dv);
          end else if (hexl) begin
            st = ST_HEX;
            add_hex(4'(c - CH_A) + 4'd10);
          end else if (c == CH_SPACE && st == ST_HEX) begin
            st = ST_TRAIL;
          end else begin
            first_error = ERR_BADCHAR;
          end
        end
        ST_TRAIL: begin
          if (c != CH_SPACE) first_error = ERR_BADCHAR;
        end
        default: begin
          first_error = ERR_BADCHAR;
        end
      endcase
    endfunction

    function void note_request(logic [7:0] c, logic is_last);
      literal_result_t r;
      if (first_error == ERR_NONE) step_recognizer(c);
      if (!is_last) return;
      r.code  = first_error;
      r.value = '0;
      if (r.code == ERR_NONE && (st == ST_START || st == ST_MINUS || st == ST_HEX0))
        r.code = ERR_BADCHAR;
      if (r.code == ERR_NONE && negative && magnitude[63]) r.code = ERR_SOVF;
      if (r.code == ERR_NONE) r.value = negative ? (~magnitude + 64'd1) : magnitude;
      expected_results.push_back(r);
      clear_literal();
    endfunction

    function void check_result(logic [63:0] value, logic [1:0] code);
      literal_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result: value %h code %0d", value, code));
        return;
      end
      want = expected_results.pop_front();
      code_count[want.code]++;
      if (value !== want.value || code !== want.code)
        report($sformatf("mismatch: expected value %h code %0d, got value %h code %0d",
                         want.value, want.code, value, code));
    endfunction

    function void close();
      if (expected_results.size() != 0)
        report($sformatf("%0d results never arrived", expected_results.size()));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lip_in_if  in_if ();
  lip_out_if out_if ();

  integer_literal_parser DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  literal_scoreboard sb;
  logic [7:0]        lit[$];
  int unsigned       sender_idle_pct;
  int unsigned       receiver_stall_pct;
  int unsigned       chars_sent;
  int unsigned       literals_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 7))
      0: return CH_0 + 8'($urandom_range(0, 9));
      1: return CH_X;
      2: return CH_A + 8'($urandom_range(0, 5));
      3: return CH_MINUS;
      4: return CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) lit.push_back(s[i]);
  endfunction

  function automatic void push_decimal(logic [63:0] v);
    logic [7:0] digits[$];
    if (v == 0) digits.push_back(CH_0);
    while (v != 0) begin
      digits.push_front(CH_0 + 8'(v % 64'd10));
      v = v / 64'd10;
    end
    lit = {lit, digits};
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? CH_0 + 8'(n) : CH_A + 8'(n - 4'd10);
  endfunction

  function automatic void push_hex(logic [63:0] v);
    logic [7:0] digits[$];
    if (v == 0) digits.push_back(CH_0);
    while (v != 0) begin
      digits.push_front(hex_char(v[3:0]));
      v = v >> 4;
    end
    lit = {lit, digits};
  endfunction

  function automatic void build_literal();
    logic [63:0] v;
    logic [63:0] delta;
    int          mode;
    bit          hex;
    bit          extra;
    lit.delete();
    hex   = ($urandom_range(0, 2) == 0);
    mode  = $urandom_range(0, 9);
    delta = 64'($urandom_range(0, 2));
    extra = (mode >= 8);
    repeat ($urandom_range(0, 2)) lit.push_back(CH_SPACE);
    if ($urandom_range(0, 2) == 0) lit.push_back(CH_MINUS);
    case (mode)
      0, 1, 2: v = 64'($urandom_range(0, 999));
      3, 4:    v = {$urandom(), $urandom()} >> $urandom_range(0, 63);
      6:       v = 64'h8000_0000_0000_0000 + delta - 64'd1;
      7:       v = 64'hFFFF_FFFF_FFFF_FFFF - delta;
      8:       v = hex ? 64'h0FFF_FFFF_FFFF_FFFF + delta - 64'd1
                       : 64'd1844674407370955161 + delta - 64'd1;
      default: v = {$urandom(), $urandom()};
    endcase
    if (hex) begin
      push_text("0x");
      repeat ($urandom_range(0, 1)) lit.push_back(CH_0);
      push_hex(v);
      if (extra) lit.push_back(hex_char(4'($urandom_range(0, 15))));
    end else begin
      if ($urandom_range(0, 3) == 0) lit.push_back(CH_0);
      push_decimal(v);
      if (extra) lit.push_back(CH_0 + 8'($urandom_range(0, 9)));
    end
    repeat ($urandom_range(0, 2)) lit.push_back(CH_SPACE);
  endfunction

  function automatic void break_literal();
    int pos;
    pos = $urandom_range(0, lit.size() - 1);
    case ($urandom_range(0, 2))
      0: lit[pos] = 8'($urandom_range(0, 255));
      1: lit = lit[0:pos];
      default: lit.insert(pos, pick_char());
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic is_last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_byte <= c;
    in_if.last      <= is_last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_request(c, is_last);
    chars_sent++;
  endtask

  task automatic send_literal();
    if (lit.size() == 0) lit.push_back(pick_char());
    foreach (lit[i]) send_char(lit[i], i == lit.size() - 1);
    literals_sent++;
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_results.size() != 0);
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.value, out_if.error_code);
      out_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_integer_literal_parser: errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sender_idle[4];
    int unsigned receiver_stall[4];
    int unsigned target;
    int          r;
    sender_idle    = '{0, 50, 0, 21};
    receiver_stall = '{0, 0, 50, 21};
    sb = new();
    chars_sent         = 0;
    literals_sent      = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.char_byte <= '0;
    in_if.last      <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    lit.delete(); push_text("0");    send_literal();
    lit.delete(); push_text("-0");   send_literal();
    lit = {8'hFF, 8'h00};            send_literal();
    lit.delete(); push_text("-");    send_literal();
    lit.delete(); push_text("0x");   send_literal();
    lit.delete(); push_text(" ");    send_literal();
    lit.delete(); push_text("-9 ");  send_literal();
    lit.delete(); push_text("0xa");  send_literal();
    lit.delete(); push_text(" 7x");  send_literal();
    wait_for_results();

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = sender_idle[phase];
      receiver_stall_pct = receiver_stall[phase];
      target = chars_sent + CharsPerPhase;
      while (chars_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          build_literal();
        end else if (r < 85) begin
          build_literal();
          break_literal();
        end else begin
          lit.delete();
          repeat ($urandom_range(1, 5)) lit.push_back(pick_char());
        end
        send_literal();
      end
      wait_for_results();
    end

    repeat (16) @(posedge clk_i);
    sb.close();
    $display("covered %0d characters in %0d literals under four idle/stall profiles",
             chars_sent, literals_sent);
    $display("results: %0d ok, %0d bad character, %0d unsigned ovf, %0d signed ovf",
             sb.code_count[ERR_NONE], sb.code_count[ERR_BADCHAR],
             sb.code_count[ERR_UOVF], sb.code_count[ERR_SOVF]);
    if (sb.mismatches == 0) begin
      $display("tb_integer_literal_parser: clean");
    end else begin
      $display("tb_integer_literal_parser: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lip_pkg.sv
rtl/lip_in_if.sv
rtl/lip_out_if.sv
rtl/integer_literal_parser.sv
tb/tb_integer_literal_parser.sv
